>>> hw/rtl/dlsc_pkg.sv
package dlsc_pkg;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [31:0] OneBits  = 32'h3F80_0000;

  localparam logic [31:0] InitScaleReset = 32'h4780_0000;
  localparam logic [31:0] GrowthReset    = 32'h4000_0000;
  localparam logic [31:0] BackoffReset   = 32'h3F00_0000;
  localparam logic [15:0] IntervalReset  = 16'd2000;

  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    RegInitScale = 2'd0,
    RegGrowth    = 2'd1,
    RegBackoff   = 2'd2,
    RegInterval  = 2'd3
  } dlsc_reg_e;

  function automatic logic is_nan(input logic [31:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

endpackage

>>> hw/rtl/dlsc_fmul.sv
// Two-stage float32 multiplier, round to nearest even, subnormals kept.
// Operands are registered, then their product; p_o is rounded combinationally.
module dlsc_fmul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  logic [23:0] ma_raw, mb_raw, ma_d, mb_d;
  logic [4:0]  na, nb;
  logic signed [10:0] ea, eb, esum_d;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic nan_d, inf_d, zero_d, sign_d;

  always_comb begin
    a_nan  = dlsc_pkg::is_nan(a_i);
    b_nan  = dlsc_pkg::is_nan(b_i);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    nan_d  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    inf_d  = a_inf || b_inf;
    zero_d = a_zero || b_zero;
    sign_d = a_i[31] ^ b_i[31];
    ma_raw = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb_raw = {b_i[30:23] != 8'd0, b_i[22:0]};
    na     = zero_d ? 5'd0 : lzc24(ma_raw);
    nb     = zero_d ? 5'd0 : lzc24(mb_raw);
    ma_d   = ma_raw << na;
    mb_d   = mb_raw << nb;
    // subnormals act as exponent one before normalising
    ea = (a_i[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, a_i[30:23]});
    eb = (b_i[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, b_i[30:23]});
    esum_d = ea - $signed({6'd0, na}) + eb - $signed({6'd0, nb}) - 11'sd127;
  end

  logic [23:0] ma_q, mb_q;
  logic signed [10:0] esum_q, esum2_q;
  logic nan_q, inf_q, zero_q, sign_q;
  logic nan2_q, inf2_q, zero2_q, sign2_q;
  logic [47:0] prod_q;

  always_ff @(posedge clk_i) begin
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    esum_q  <= esum_d;
    nan_q   <= nan_d;
    inf_q   <= inf_d;
    zero_q  <= zero_d;
    sign_q  <= sign_d;
    prod_q  <= ma_q * mb_q;
    esum2_q <= esum_q;
    nan2_q  <= nan_q;
    inf2_q  <= inf_q;
    zero2_q <= zero_q;
    sign2_q <= sign_q;
  end

  logic [47:0] sig, shifted;
  logic signed [10:0] e1, sh;
  logic [5:0]  sh6;
  logic [7:0]  efield;
  logic [23:0] mant;
  logic        g, st, inc, ovf;
  logic [30:0] rnd_word;

  always_comb begin
    if (prod_q[47]) begin
      sig = prod_q;
      e1  = esum2_q + 11'sd1;
    end else begin
      sig = {prod_q[46:0], 1'b0};
      e1  = esum2_q;
    end
    sh      = 11'sd1 - e1;
    sh6     = (sh > 11'sd47) ? 6'd48 : sh[5:0];
    shifted = sig;
    efield  = e1[7:0];
    ovf     = (e1 >= 11'sd255);
    st      = 1'b0;
    if (e1 < 11'sd1) begin
      // gradual underflow: shift into the subnormal range, collect sticky
      shifted = sig >> sh6;
      st      = |(sig & ~({48{1'b1}} << sh6));
      efield  = 8'd0;
    end
    mant     = shifted[47:24];
    g        = shifted[23];
    st       = st | (|shifted[22:0]);
    inc      = g & (st | mant[0]);
    rnd_word = {efield, mant[22:0]} + {30'd0, inc};

    if (nan2_q) begin
      p_o = dlsc_pkg::CanonNan;
    end else if (inf2_q || (!zero2_q && ovf)) begin
      p_o = {sign2_q, 8'hFF, 23'd0};
    end else if (zero2_q) begin
      p_o = {sign2_q, 31'd0};
    end else begin
      p_o = {sign2_q, rnd_word};
    end
  end

endmodule

>>> hw/rtl/dynamic_loss_scale_controller_unit.sv
// Dynamic loss-scale controller.
// Input channel: one float32 gradient word per accepted transfer, with
// last_of_step_i marking the final word of a training step. Non-last words
// are taken every cycle; they only update the non-finite flag.
// Output channel: one word per step (skip flag, new scale, good-step count),
// held in an output register until taken.
// The result goes from the last word through the update pipe and the float32
// multiplier, which has two internal register stages, into the output register.
// Throughput: one word per cycle. A last word is held off while the previous
// step's update is still in the multiplier or its result waits unread, so one
// step's update is complete before the next step's update starts.
// Receiver stalls never block non-last words.
// APB port: registers initial scale (0x0), growth (0x4), backoff (0x8) and
// interval (0xC); writing the initial scale also loads the live scale.
// Reset loads the default registers, the scale 65536.0, a zero count and an
// empty output register.
module dynamic_loss_scale_controller_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dlsc_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    gradient_word_i,
  input  logic                           last_of_step_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           skip_step_o,
  output logic [31:0]                    new_scale_bits_o,
  output logic [15:0]                    good_steps_o
);

  logic [31:0] init_q, growth_q, backoff_q, scale_q;
  logic [15:0] interval_q, cnt_q;
  logic        seen_q, skip_q;
  logic [2:0]  upd_q;
  logic        out_v_q;
  logic        busy, in_acc, cfg_wr;
  dlsc_pkg::dlsc_reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dlsc_pkg::dlsc_reg_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      dlsc_pkg::RegInitScale: prdata = init_q;
      dlsc_pkg::RegGrowth:    prdata = growth_q;
      dlsc_pkg::RegBackoff:   prdata = backoff_q;
      dlsc_pkg::RegInterval:  prdata = {16'd0, interval_q};
      default:                prdata = 32'd0;
    endcase
  end

  assign busy       = |upd_q;
  assign in_ready_o = !last_of_step_i || (!busy && (!out_v_q || out_ready_i));
  assign in_acc     = in_valid_i && in_ready_o;

  // operand selection for the cycle after a last word
  logic [31:0] scale_c, mul_b;
  logic [15:0] cnt_inc, cnt_d;
  logic        grow;
  logic [31:0] prod;

  always_comb begin
    scale_c = dlsc_pkg::is_nan(scale_q) ? dlsc_pkg::CanonNan : scale_q;
    mul_b   = skip_q ? backoff_q : growth_q;
    cnt_inc = cnt_q + 16'd1;
    grow    = (cnt_inc >= interval_q);
    cnt_d   = (skip_q || grow) ? 16'd0 : cnt_inc;
  end

  dlsc_fmul u_fmul (
    .clk_i (clk_i),
    .a_i   (scale_c),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  logic [31:0] side_scale_q;
  logic [15:0] side_cnt_q;
  logic        side_mul_q, side_skip_q;
  logic [31:0] res;
  logic        less1;

  always_comb begin
    res   = side_mul_q ? prod : side_scale_q;
    less1 = res[31] ? 1'b1 : (res[30:0] < dlsc_pkg::OneBits[30:0]);
    // clamp after backoff; a NaN scale stays NaN
    if (side_skip_q && !dlsc_pkg::is_nan(res) && less1) res = dlsc_pkg::OneBits;
  end

  always_ff @(posedge clk_i) begin
    if (upd_q[0]) begin
      side_scale_q <= scale_c;
      side_cnt_q   <= cnt_d;
      side_mul_q   <= skip_q || grow;
      side_skip_q  <= skip_q;
    end
    if (upd_q[2]) begin
      skip_step_o      <= side_skip_q;
      new_scale_bits_o <= res;
      good_steps_o     <= side_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= dlsc_pkg::InitScaleReset;
      growth_q   <= dlsc_pkg::GrowthReset;
      backoff_q  <= dlsc_pkg::BackoffReset;
      interval_q <= dlsc_pkg::IntervalReset;
      scale_q    <= dlsc_pkg::InitScaleReset;
      cnt_q      <= 16'd0;
      seen_q     <= 1'b0;
      skip_q     <= 1'b0;
      upd_q      <= 3'd0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          dlsc_pkg::RegInitScale: begin
            init_q  <= pwdata;
            scale_q <= pwdata;
          end
          dlsc_pkg::RegGrowth:   growth_q   <= pwdata;
          dlsc_pkg::RegBackoff:  backoff_q  <= pwdata;
          dlsc_pkg::RegInterval: interval_q <= pwdata[15:0];
          default: ;
        endcase
      end
      upd_q <= {upd_q[1:0], in_acc && last_of_step_i};
      if (in_acc) begin
        if (last_of_step_i) begin
          skip_q <= seen_q || (gradient_word_i[30:23] == 8'hFF);
          seen_q <= 1'b0;
        end else begin
          seen_q <= seen_q || (gradient_word_i[30:23] == 8'hFF);
        end
      end
      if (upd_q[2]) begin
        scale_q <= res;
        cnt_q   <= side_cnt_q;
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(upd_q))
    else $error("more than one scale update in flight");

  a_no_last_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_of_step_i) |-> !busy)
    else $error("last word accepted during an update");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(upd_q[2]))
    else $error("result raised without an update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_q[2] |-> (!out_v_q || out_ready_i))
    else $error("pending result overwritten");

endmodule
